[rtl/mono_glyph_span_extract_unit_defines.svh]
// Assertion macros used by the span extractor back end.
`ifndef MONO_GLYPH_SPAN_EXTRACT_UNIT_DEFINES_SVH
`define MONO_GLYPH_SPAN_EXTRACT_UNIT_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define MGSE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define MGSE_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

[rtl/mgse_pkg.sv]
// Types and constants shared by the glyph span extractor modules.
package mgse_pkg;

   localparam int ROW_BITS_W = 64;
   localparam int WIDTH_W    = 7;
   localparam int INDEX_W    = 16;
   localparam int COORD_W    = 16;
   localparam int X0_W       = 17;
   localparam int SPAN_W     = 18;
   localparam int LEN_W      = 7;
   localparam int PAIRS_W    = 7;

   // One classified row waiting for the scanner
   typedef struct packed {
      logic [ROW_BITS_W-1:0] bits;
      logic [PAIRS_W-1:0]    npairs;
      logic [X0_W-1:0]       x0;
      logic [SPAN_W-1:0]     y;
   } row_entry_type;

   // Handshake between queue and scanner
   typedef struct packed {
      logic valid;
      logic pop;
   } queue_ctl_type;

endpackage

[rtl/mgse_front.sv]
// Front end: accept a request, clip the row to its width and form the coordinates.
module mgse_front import mgse_pkg::*; #(
   parameter int RowW = 64
) (
   input  logic                        req_valid,
   input  logic [ROW_BITS_W-1:0]       req_row_bits,
   input  logic [WIDTH_W-1:0]          req_glyph_width,
   input  logic [INDEX_W-1:0]          req_row_index,
   input  logic signed [COORD_W-1:0]   req_pen_x,
   input  logic signed [COORD_W-1:0]   req_pen_y,
   input  logic signed [COORD_W-1:0]   req_bearing_x,
   input  logic signed [COORD_W-1:0]   req_bearing_y,
   input  logic                        q_full,
   output logic                        req_stall,
   output logic                        push,
   output row_entry_type               push_ent
);

   logic [WIDTH_W-1:0]    w_sat;
   logic [ROW_BITS_W-1:0] keep_mask;

   // Saturate the width and blank pixels beyond it
   always_comb begin
      if (req_glyph_width > WIDTH_W'(RowW)) begin
         w_sat = WIDTH_W'(RowW);
      end else begin
         w_sat = req_glyph_width;
      end
      keep_mask = ~({ROW_BITS_W{1'b1}} >> w_sat);
   end

   // Build the queue entry
   always_comb begin
      push_ent.bits   = req_row_bits & keep_mask;
      push_ent.npairs = PAIRS_W'(w_sat[WIDTH_W-1:1]) + PAIRS_W'(1);
      push_ent.x0     = X0_W'(req_pen_x) - X0_W'(req_bearing_x);
      push_ent.y      = SPAN_W'(req_pen_y) - SPAN_W'(req_bearing_y)
                        + {2'b00, req_row_index};
   end

   assign req_stall = q_full;
   assign push      = req_valid & ~q_full;

endmodule

[rtl/mgse_queue.sv]
// Two-entry queue between the front end and the scanner.
module mgse_queue import mgse_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  row_entry_type push_ent,
   output logic          full,
   input  queue_ctl_type ctl_in,
   output queue_ctl_type ctl_out,
   output row_entry_type head_ent
);

   row_entry_type slot_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          pop;

   assign pop  = ctl_in.pop & (count_ff != 2'd0);
   assign full = (count_ff == 2'd2);

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed request
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_ent;
      end
   end

   always_comb begin
      ctl_out.valid = (count_ff != 2'd0);
      ctl_out.pop   = pop;
      head_ent      = slot_ff[rd_ptr_ff];
   end

endmodule

[rtl/mgse_back.sv]
// Back end: scan two pixels a cycle unless stalled; emit spans.
`include "mono_glyph_span_extract_unit_defines.svh"
module mgse_back import mgse_pkg::*; #(
   parameter int RowW = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  queue_ctl_type             q_ctl,
   input  row_entry_type             q_ent,
   output queue_ctl_type             q_req,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [SPAN_W-1:0]  rsp_span_x,
   output logic signed [SPAN_W-1:0]  rsp_span_y,
   output logic [LEN_W-1:0]          rsp_span_len,
   output logic                      rsp_last_span
);

   localparam int WinW = RowW + 2;
   localparam int PosW = $clog2(RowW + 2);

   // Scanner state
   logic                busy_ff, busy_in;
   logic [WinW-1:0]     bits_ff, bits_in;
   logic [PosW-1:0]     pos_ff, pos_in;
   logic                run_on_ff, run_on_in;
   logic [PosW-1:0]     run_start_ff, run_start_in;
   logic [PAIRS_W-1:0]  pairs_ff, pairs_in;
   logic [X0_W-1:0]     x0_ff, x0_in;
   logic [SPAN_W-1:0]   y_ff, y_in;

   // Pending span, held until it is known whether it is the last
   logic                pend_v_ff, pend_v_in;
   logic [SPAN_W-1:0]   pend_x_ff, pend_x_in;
   logic [LEN_W-1:0]    pend_len_ff, pend_len_in;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SPAN_W-1:0]   rsp_x_ff, rsp_x_in;
   logic [SPAN_W-1:0]   rsp_y_ff, rsp_y_in;
   logic [LEN_W-1:0]    rsp_len_ff, rsp_len_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                b0, b1, end0, end1, end_now;
   logic [PosW-1:0]     pos_inc, end_start, end_pos;
   logic                out_free, adv, move, load;

   // Classify the current pixel pair
   always_comb begin
      b0        = bits_ff[WinW-1];
      b1        = bits_ff[WinW-2];
      pos_inc   = pos_ff + PosW'(1);
      end0      = run_on_ff & ~b0;
      end1      = b0 & ~b1;
      end_now   = busy_ff & (end0 | end1);
      end_start = run_on_ff ? run_start_ff : pos_ff;
      end_pos   = end0 ? pos_ff : pos_inc;
   end

   // Hand-off decisions
   always_comb begin
      out_free = ~rsp_valid_ff | ~rsp_stall;
      adv      = busy_ff & ~(end_now & pend_v_ff & ~out_free);
      move     = pend_v_ff & out_free & ((adv & end_now) | ~busy_ff);
      load     = ~busy_ff & ~pend_v_ff & q_ctl.valid;
      q_req.valid = 1'b0;
      q_req.pop   = load;
   end

   // Advance the scanner
   always_comb begin
      busy_in      = busy_ff;
      bits_in      = bits_ff;
      pos_in       = pos_ff;
      run_on_in    = run_on_ff;
      run_start_in = run_start_ff;
      pairs_in     = pairs_ff;
      x0_in        = x0_ff;
      y_in         = y_ff;
      if (load) begin
         busy_in      = 1'b1;
         bits_in      = {q_ent.bits[ROW_BITS_W-1 -: RowW], 2'b00};
         pos_in       = '0;
         run_on_in    = 1'b0;
         run_start_in = '0;
         pairs_in     = q_ent.npairs;
         x0_in        = q_ent.x0;
         y_in         = q_ent.y;
      end else if (adv) begin
         bits_in      = bits_ff << 2;
         pos_in       = pos_ff + PosW'(2);
         run_on_in    = b1;
         run_start_in = b0 ? end_start : pos_inc;
         pairs_in     = pairs_ff - PAIRS_W'(1);
         if (pairs_ff == PAIRS_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // Update the pending span
   always_comb begin
      pend_v_in   = pend_v_ff;
      pend_x_in   = pend_x_ff;
      pend_len_in = pend_len_ff;
      if (adv && end_now) begin
         pend_v_in   = 1'b1;
         pend_x_in   = SPAN_W'(signed'(x0_ff)) + SPAN_W'(end_start);
         pend_len_in = LEN_W'(end_pos - end_start);
      end else if (move) begin
         pend_v_in = 1'b0;
      end
   end

   // Load or hold the result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_last_in  = rsp_last_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = pend_x_ff;
         rsp_y_in     = y_ff;
         rsp_len_in   = pend_len_ff;
         rsp_last_in  = ~busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff      <= bits_in;
      pos_ff       <= pos_in;
      run_on_ff    <= run_on_in;
      run_start_ff <= run_start_in;
      pairs_ff     <= pairs_in;
      x0_ff        <= x0_in;
      y_ff         <= y_in;
      pend_x_ff    <= pend_x_in;
      pend_len_ff  <= pend_len_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_span_x    = signed'(rsp_x_ff);
   assign rsp_span_y    = signed'(rsp_y_ff);
   assign rsp_span_len  = rsp_len_ff;
   assign rsp_last_span = rsp_last_ff;

   // Scanner and span checks
   `MGSE_ASSERT(a_busy_pairs, busy_ff |-> pairs_ff != '0, "scanner busy with no pairs left")
   `MGSE_ASSERT(a_len_nonzero, rsp_valid_ff |-> rsp_len_ff != '0, "span of zero length")
   `MGSE_ASSERT(a_last_drains, (move && !busy_ff) |=> !pend_v_ff, "final span not drained")
   `MGSE_ASSERT(a_pend_hold, (end_now && pend_v_ff && !out_free) |=> pend_v_ff && $stable(pend_x_ff), "pending span lost while blocked")
   `MGSE_NEVER(a_load_busy, load && (busy_ff || pend_v_ff), "row loaded over unfinished work")

endmodule

[rtl/mono_glyph_span_extract_unit.sv]
// Top level of the 1bpp glyph row span extractor.
// One request carries one glyph row; it yields one response per run of set pixels within
// the row's width, left to right, with the final one flagged, and none for an empty row.
// The scanner walks the row two pixels a cycle, covering floor(W/2)+1 pixel pairs for
// a row of width W (33 for a full 64-pixel row); a row is first loaded from the queue
// and, when it has any span, its last span is then handed to the response register; spans
// leave at most one a cycle, and the scanner pauses only while a finished span waits
// behind a stalled response.
// A two-entry request queue lets the next rows be taken while a row is being scanned.
module mono_glyph_span_extract_unit import mgse_pkg::*; #(
   parameter int MAX_ROW_WIDTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [ROW_BITS_W-1:0]     req_row_bits,
   input  logic [WIDTH_W-1:0]        req_glyph_width,
   input  logic [INDEX_W-1:0]        req_row_index,
   input  logic signed [COORD_W-1:0] req_pen_x,
   input  logic signed [COORD_W-1:0] req_pen_y,
   input  logic signed [COORD_W-1:0] req_bearing_x,
   input  logic signed [COORD_W-1:0] req_bearing_y,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [SPAN_W-1:0]  rsp_span_x,
   output logic signed [SPAN_W-1:0]  rsp_span_y,
   output logic [LEN_W-1:0]          rsp_span_len,
   output logic                      rsp_last_span
);

   logic          push;
   logic          q_full;
   row_entry_type push_ent;
   row_entry_type head_ent;
   queue_ctl_type q_status;
   queue_ctl_type q_pop_req;

   // Classify incoming rows
   mgse_front #(.RowW(MAX_ROW_WIDTH)) u_front (
      .req_valid       (req_valid),
      .req_row_bits    (req_row_bits),
      .req_glyph_width (req_glyph_width),
      .req_row_index   (req_row_index),
      .req_pen_x       (req_pen_x),
      .req_pen_y       (req_pen_y),
      .req_bearing_x   (req_bearing_x),
      .req_bearing_y   (req_bearing_y),
      .q_full          (q_full),
      .req_stall       (req_stall),
      .push            (push),
      .push_ent        (push_ent)
   );

   // Buffer rows between the two halves
   mgse_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_ent (push_ent),
      .full     (q_full),
      .ctl_in   (q_pop_req),
      .ctl_out  (q_status),
      .head_ent (head_ent)
   );

   // Scan rows into spans
   mgse_back #(.RowW(MAX_ROW_WIDTH)) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_ctl         (q_status),
      .q_ent         (head_ent),
      .q_req         (q_pop_req),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_span_x    (rsp_span_x),
      .rsp_span_y    (rsp_span_y),
      .rsp_span_len  (rsp_span_len),
      .rsp_last_span (rsp_last_span)
   );

endmodule
